// ===== hdl/gtsn_pkg.sv =====
// ----------------------------------------------------------------------------
// gtsn_pkg
// Shared constants and types for the time to slot number converter: field
// widths, status codes, register indexes and the divider stage record.
// ----------------------------------------------------------------------------
package gtsn_pkg;

    // field widths
    localparam int TIME_W   = 64;
    localparam int FRAC_W   = 32;
    localparam int SCALE_W  = 8;
    localparam int FRAME_W  = 32;
    localparam int CFG_IDX_W = 2;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 248;
    localparam int M_TDATA_W = 104;

    // microseconds per second and the constant multiplier width
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;

    // partial products of a 32-bit half of the seconds by one million
    localparam int HALF_W = TIME_W / 2;
    localparam int PP_W   = HALF_W + US_W;
    // full sample time before the overflow check
    localparam int FULL_W = PP_W + HALF_W;

    // accepted stratum range
    localparam logic [SCALE_W-1:0] STRATUM_MAX = 8'd4;

    // one quotient bit per divider stage
    localparam int DIV_STAGES = TIME_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UTC_SCALE     = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INTERVAL  = 3'd1,
        ST_UNTRUSTED = 3'd2,
        ST_RANGE     = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_STALE     = 3'd5
    } t_status;

    // one divider stage: partial remainder and shared dividend/quotient word
    typedef struct packed {
        logic              valid;
        t_status           status;
        logic              clamped;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] dq;
    } t_div_stage;

endpackage

// ===== hdl/gnss_time_to_slot_number.sv =====
// ----------------------------------------------------------------------------
// gnss_time_to_slot_number
// Turns a raw microsecond time or a checked GNSS time sample into an absolute
// slot number and frame number relative to a configured epoch and interval.
// ----------------------------------------------------------------------------
// Usage
//   Input words arrive on the s-side stream: tuser selects the mode (0 raw
//   microseconds, 1 GNSS sample), tdata carries the time fields. Each input
//   word gives exactly one result word on the m-side stream, in order.
//   Configuration (epoch base, slot interval, UTC scale code) is written
//   through the i_cfg_* port while no word is in flight.
// Throughput and pipeline
//   One word per cycle, sustained while o_s_tready stays high. A word passes 68
//   registers, the first loaded at the edge that accepts it: three front
//   stages (early checks with seconds times one million as two partial
//   products, the sum and overflow check, stale and epoch checks with the
//   epoch subtract), a restoring divider of 64 stages, one quotient bit per
//   stage, then the output register.
// Reset
//   i_rst_n clears configuration and valid flags, emptying the pipeline.
// Back pressure
//   A result waiting on o_m_tvalid does not stop input; a second result
//   goes to a skid register, and only while that is full does o_s_tready
//   drop and the whole pipeline hold. No word is lost or repeated.
// ----------------------------------------------------------------------------
module gnss_time_to_slot_number
    import gtsn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [TIME_W-1:0]      i_cfg_data,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // raw_time_us, wall_clk_ok, time_src_ok, time_scale, stratum,
    // whole_seconds, fraction_us, epoch_floor_us, zero pad
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    // action
    input  logic                   i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status, slot_number, frame_number, clamped, zero pad
    output logic [M_TDATA_W-1:0]   o_m_tdata
);

    // configuration registers
    logic [TIME_W-1:0]  r_epoch_base_us;
    logic [TIME_W-1:0]  r_slot_interval_us;
    logic [SCALE_W-1:0] r_utc_scale_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_base_us    <= '0;
            r_slot_interval_us <= '0;
            r_utc_scale_code   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_EPOCH_BASE:    r_epoch_base_us    <= i_cfg_data;
                CFG_SLOT_INTERVAL: r_slot_interval_us <= i_cfg_data;
                CFG_UTC_SCALE:     r_utc_scale_code   <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless the skid register is full
    logic r_skid_valid;
    logic w_en;
    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    // input field unpacking
    logic [TIME_W-1:0]  w_raw_time_us;
    logic               w_wall_clk_ok;
    logic               w_time_src_ok;
    logic [SCALE_W-1:0] w_time_scale;
    logic [SCALE_W-1:0] w_stratum;
    logic [TIME_W-1:0]  w_whole_seconds;
    logic [FRAC_W-1:0]  w_fraction_us;
    logic [TIME_W-1:0]  w_epoch_floor_us;

    assign w_raw_time_us      = i_s_tdata[63:0];
    assign w_wall_clk_ok      = i_s_tdata[64];
    assign w_time_src_ok      = i_s_tdata[65];
    assign w_time_scale       = i_s_tdata[73:66];
    assign w_stratum          = i_s_tdata[81:74];
    assign w_whole_seconds    = i_s_tdata[145:82];
    assign w_fraction_us      = i_s_tdata[177:146];
    assign w_epoch_floor_us   = i_s_tdata[241:178];

    // ------------------------------------------------------------------
    // stage 1: early checks and seconds times one million in two halves
    // ------------------------------------------------------------------
    logic               r1_valid;
    logic               r1_action;
    logic               r1_hit;
    t_status            r1_status;
    logic [TIME_W-1:0]  r1_raw;
    logic [PP_W-1:0]    r1_pp_lo;
    logic [PP_W-1:0]    r1_pp_hi;
    logic [FRAC_W-1:0]  r1_frac;
    logic [TIME_W-1:0]  r1_floor;

    logic    n1_hit;
    t_status n1_status;
    logic    w_untrusted;
    logic    w_out_range;

    assign w_untrusted = !w_wall_clk_ok || !w_time_src_ok
                      || (w_time_scale != r_utc_scale_code)
                      || (w_stratum == '0) || (w_stratum > STRATUM_MAX);
    assign w_out_range = w_whole_seconds[TIME_W-1]
                      || (w_fraction_us >= FRAC_W'(US_PER_SECOND));

    // first failing check decides the sample status
    always_comb begin
        n1_hit    = 1'b1;
        n1_status = ST_OK;
        if (r_slot_interval_us == '0) begin
            n1_status = ST_INTERVAL;
        end else if (w_untrusted) begin
            n1_status = ST_UNTRUSTED;
        end else if (w_out_range) begin
            n1_status = ST_RANGE;
        end else begin
            n1_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_action <= i_s_tuser;
            r1_hit    <= n1_hit;
            r1_status <= n1_status;
            r1_raw    <= w_raw_time_us;
            r1_pp_lo  <= PP_W'(w_whole_seconds[HALF_W-1:0]) * PP_W'(US_PER_SECOND);
            r1_pp_hi  <= PP_W'(w_whole_seconds[TIME_W-1:HALF_W]) * PP_W'(US_PER_SECOND);
            r1_frac   <= w_fraction_us;
            r1_floor  <= w_epoch_floor_us;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sample time sum, overflow check, mode select
    // ------------------------------------------------------------------
    logic               r2_valid;
    logic               r2_action;
    logic               r2_hit;
    t_status            r2_status;
    logic [TIME_W-1:0]  r2_time;
    logic [TIME_W-1:0]  r2_floor;

    logic [FULL_W-1:0]  w_full;
    logic               w_ovf;

    assign w_full = {r1_pp_hi, {HALF_W{1'b0}}} + FULL_W'(r1_pp_lo) + FULL_W'(r1_frac);
    assign w_ovf  = |w_full[FULL_W-1:TIME_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_action <= r1_action;
            r2_floor  <= r1_floor;
            r2_time   <= r1_action ? w_full[TIME_W-1:0] : r1_raw;
            if (r1_action && !r1_hit && w_ovf) begin
                r2_hit    <= 1'b1;
                r2_status <= ST_OVERFLOW;
            end else begin
                r2_hit    <= r1_hit;
                r2_status <= r1_status;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: stale and epoch checks, dividend
    // ------------------------------------------------------------------
    t_div_stage r_div [0:DIV_STAGES];
    t_div_stage n3_div;

    logic w_before_epoch;
    assign w_before_epoch = r2_time < r_epoch_base_us;

    always_comb begin
        n3_div         = '0;
        n3_div.valid   = r2_valid;
        n3_div.dq      = r2_time - r_epoch_base_us;
        if (!r2_action) begin
            // raw mode reports ok, forced to zero on a bad interval or epoch
            n3_div.status  = ST_OK;
            n3_div.clamped = (r_slot_interval_us == '0) || w_before_epoch;
        end else if (r2_hit) begin
            n3_div.status = r2_status;
        end else if (r2_time < r2_floor) begin
            n3_div.status = ST_STALE;
        end else if (w_before_epoch) begin
            n3_div.status = ST_RANGE;
        end else begin
            n3_div.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0].valid <= 1'b0;
        end else if (w_en) begin
            r_div[0] <= n3_div;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [TIME_W:0]   w_trial;
        logic [TIME_W:0]   w_diff;
        logic              w_ge;
        t_div_stage        n_div;

        assign w_trial = {r_div[k].rem, r_div[k].dq[TIME_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_slot_interval_us};
        assign w_diff  = w_trial - {1'b0, r_slot_interval_us};

        always_comb begin
            n_div     = r_div[k];
            n_div.rem = w_ge ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
            n_div.dq  = {r_div[k].dq[TIME_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k+1].valid <= 1'b0;
            end else if (w_en) begin
                r_div[k+1] <= n_div;
            end
        end
    end

    // ------------------------------------------------------------------
    // result packing, output register and skid register
    // ------------------------------------------------------------------
    t_div_stage         w_last;
    logic [TIME_W-1:0]  w_slot;
    logic [M_TDATA_W-1:0] w_word;

    assign w_last = r_div[DIV_STAGES];
    assign w_slot = (w_last.status == ST_OK && !w_last.clamped) ? w_last.dq : '0;
    assign w_word = {4'b0000, w_last.clamped, w_slot[FRAME_W-1:0], w_slot,
                     w_last.status};

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] r_skid_data;
    logic                 w_pop;
    logic                 w_push;

    assign w_pop  = r_out_valid && i_m_tready;
    assign w_push = w_en && w_last.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // pipeline holds; drain the skid word into the output register
            if (w_pop) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_data  <= w_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= w_word;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== tb/sv/gnss_time_to_slot_number_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gnss_time_to_slot_number_test
// Self-checking bench for the time to slot number converter. Directed words
// cover reset defaults, raw clamping, every sample check in priority order
// and register extremes. Random phases then run mostly well-formed samples
// and raw words under several register settings, most with random stalls on
// both streams. Every result word is compared with an in-bench prediction.
// ----------------------------------------------------------------------------
module gnss_time_to_slot_number_test;
    import gtsn_pkg::*;

    // spare register index, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // largest seconds value whose microsecond time still fits 64 bits
    localparam logic [TIME_W-1:0] MAX_WHOLE_SECONDS = 64'd18446744073709;
    localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

    typedef struct packed {
        logic                 action;
        logic [TIME_W-1:0]    raw_time_us;
        logic                 wall_clk_ok;
        logic                 time_src_ok;
        logic [SCALE_W-1:0]   time_scale;
        logic [SCALE_W-1:0]   stratum;
        logic [TIME_W-1:0]    whole_seconds;
        logic [FRAC_W-1:0]    fraction_us;
        logic [TIME_W-1:0]    epoch_floor_us;
    } t_time_word;

    typedef struct packed {
        t_status              status;
        logic [TIME_W-1:0]    slot_number;
        logic [FRAME_W-1:0]   frame_number;
        logic                 clamped;
    } t_slot_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [TIME_W-1:0]      i_cfg_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // raw_time_us, wall_clk_ok, time_src_ok, time_scale, stratum,
    // whole_seconds, fraction_us, epoch_floor_us, zero pad
    logic [S_TDATA_W-1:0]   i_s_tdata;
    // action
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // status, slot_number, frame_number, clamped, zero pad
    logic [M_TDATA_W-1:0]   o_m_tdata;

    // bench copy of the registers
    logic [TIME_W-1:0]      cfg_epoch;
    logic [TIME_W-1:0]      cfg_interval;
    logic [SCALE_W-1:0]     cfg_scale;

    t_slot_result           slot_want_q[$];
    int unsigned            errors;
    int unsigned            raw_words;
    int unsigned            sample_words;
    int unsigned            checked_words;
    int unsigned            clamp_hits;
    int unsigned            reg_writes;
    int unsigned            status_hits[6];
    bit                     src_idle_on;
    bit                     sink_idle_on;
    int unsigned            sink_hold = 0;

    gnss_time_to_slot_number DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // slot number and status for one input word under the current registers
    function automatic t_slot_result predict_slot(input t_time_word w);
        t_slot_result      r;
        logic [127:0]      wide_us;
        logic [TIME_W-1:0] t_us;
        r = '0;
        r.status = ST_OK;
        if (!w.action) begin
            if (cfg_interval == 0 || w.raw_time_us < cfg_epoch) begin
                r.clamped = 1'b1;
            end else begin
                r.slot_number = (w.raw_time_us - cfg_epoch) / cfg_interval;
            end
        end else begin
            wide_us = {64'd0, w.whole_seconds} * 128'd1000000 + {96'd0, w.fraction_us};
            t_us = wide_us[63:0];
            if (cfg_interval == 0) begin
                r.status = ST_INTERVAL;
            end else if (!w.wall_clk_ok || !w.time_src_ok ||
                         w.time_scale != cfg_scale ||
                         w.stratum == 0 || w.stratum > STRATUM_MAX) begin
                r.status = ST_UNTRUSTED;
            end else if (w.whole_seconds[TIME_W-1] ||
                         w.fraction_us >= FRAC_W'(US_PER_SECOND)) begin
                r.status = ST_RANGE;
            end else if (wide_us[127:64] != 0) begin
                r.status = ST_OVERFLOW;
            end else if (t_us < w.epoch_floor_us) begin
                r.status = ST_STALE;
            end else if (t_us < cfg_epoch) begin
                r.status = ST_RANGE;
            end else begin
                r.slot_number = (t_us - cfg_epoch) / cfg_interval;
            end
        end
        r.frame_number = r.slot_number[FRAME_W-1:0];
        return r;
    endfunction

    // input gap: mostly none or short, a few long
    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!src_idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned stall_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // every field random, action too
    function automatic t_time_word noise_word();
        t_time_word w;
        w.action           = 1'($urandom_range(0, 1));
        w.raw_time_us      = rand64();
        w.wall_clk_ok      = 1'($urandom_range(0, 1));
        w.time_src_ok      = 1'($urandom_range(0, 1));
        w.time_scale       = 8'($urandom_range(0, 255));
        w.stratum          = 8'($urandom_range(0, 255));
        w.whole_seconds    = rand64();
        w.fraction_us      = $urandom;
        w.epoch_floor_us   = rand64();
        return w;
    endfunction

    // trusted sample with the given time, no floor
    function automatic t_time_word good_sample(input logic [TIME_W-1:0] secs,
                                               input logic [FRAC_W-1:0] frac,
                                               input logic [SCALE_W-1:0] strat);
        t_time_word w;
        w = '0;
        w.action           = 1'b1;
        w.raw_time_us      = rand64();
        w.wall_clk_ok      = 1'b1;
        w.time_src_ok      = 1'b1;
        w.time_scale       = cfg_scale;
        w.stratum          = strat;
        w.whole_seconds    = secs;
        w.fraction_us      = frac;
        return w;
    endfunction

    // raw word near the epoch, below it, on slot edges, or anywhere
    function automatic t_time_word make_raw_word();
        t_time_word w;
        w = noise_word();
        w.action = 1'b0;
        case ($urandom_range(0, 3))
            0: begin
                w.raw_time_us = rand64();
            end
            1: begin
                w.raw_time_us = cfg_epoch + 64'($urandom_range(0, 5000));
            end
            2: begin
                w.raw_time_us = cfg_epoch - 64'($urandom_range(1, 5000));
            end
            default: begin
                w.raw_time_us = cfg_epoch + cfg_interval * 64'($urandom_range(0, 50))
                              + 64'($urandom_range(0, 2));
            end
        endcase
        return w;
    endfunction

    // sample near or after the epoch, with one flaw now and then
    function automatic t_time_word make_sample_word(input int unsigned flaw_pct);
        t_time_word        w;
        logic [TIME_W-1:0] base_s;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] offset;
        logic [TIME_W-1:0] t_us;
        base_s = cfg_epoch / 64'd1000000;
        span   = MAX_WHOLE_SECONDS - base_s;
        offset = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(0, 2000)) : rand64();
        offset = (span != 0) ? offset % (span + 1) : 64'd0;
        w = good_sample(base_s + offset, $urandom_range(0, 999999),
                        8'($urandom_range(1, 4)));
        t_us = w.whole_seconds * 64'd1000000 + 64'(w.fraction_us);
        case ($urandom_range(0, 2))
            0: w.epoch_floor_us = 64'd0;
            1: w.epoch_floor_us = t_us >> $urandom_range(0, 63);
            default: w.epoch_floor_us = t_us;
        endcase
        if ($urandom_range(0, 99) < flaw_pct) begin
            case ($urandom_range(0, 8))
                0: w.wall_clk_ok = 1'b0;
                1: w.time_src_ok = 1'b0;
                2: w.time_scale = cfg_scale ^ SCALE_W'($urandom_range(1, 255));
                3: w.stratum = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(5, 255));
                4: w.whole_seconds[TIME_W-1] = 1'b1;
                5: w.fraction_us = $urandom_range(1000000, 32'hFFFF_FFFF);
                6: w.whole_seconds = MAX_WHOLE_SECONDS + 64'd1 + {32'd0, $urandom};
                7: w.epoch_floor_us = t_us + 64'd1 + 64'($urandom_range(0, 1000));
                default: w = noise_word();
            endcase
        end
        return w;
    endfunction

    // drive one word, wait for acceptance, then an optional gap
    task automatic send_word(input t_time_word w);
        int unsigned gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= w.action;
        i_s_tdata  <= {6'd0, w.epoch_floor_us, w.fraction_us, w.whole_seconds,
                       w.stratum, w.time_scale, w.time_src_ok, w.wall_clk_ok,
                       w.raw_time_us};
        do @(posedge i_clk); while (!o_s_tready);
        slot_want_q.push_back(predict_slot(w));
        if (w.action) sample_words++;
        else raw_words++;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop input and let every pending result word drain
    task automatic wait_for_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (slot_want_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [TIME_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_EPOCH_BASE:    cfg_epoch = value;
            CFG_SLOT_INTERVAL: cfg_interval = value;
            CFG_UTC_SCALE:     cfg_scale = value[SCALE_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_registers(input logic [TIME_W-1:0] epoch,
                                 input logic [TIME_W-1:0] interval,
                                 input logic [SCALE_W-1:0] scale);
        wait_for_results();
        write_reg(CFG_EPOCH_BASE, epoch);
        write_reg(CFG_SLOT_INTERVAL, interval);
        // junk above the scale byte must be dropped
        write_reg(CFG_UTC_SCALE, {56'($urandom_range(0, 255) << 16 | $urandom), scale});
    endtask

    // registers still at reset: zero interval wins over everything
    task automatic test_reset_defaults();
        t_time_word w;
        w = noise_word();
        w.action = 1'b0;
        send_word(w);
        w = good_sample(64'd5, 32'd0, 8'd9);
        w.wall_clk_ok = 1'b0;
        send_word(w);
    endtask

    // raw mode: clamp below the epoch, slot edges, full range
    task automatic test_raw_mode();
        t_time_word w;
        set_registers(64'd1000, 64'd7, 8'h00);
        w = noise_word();
        w.action = 1'b0;
        w.raw_time_us = 64'd999;
        send_word(w);
        w.raw_time_us = 64'd1000;
        send_word(w);
        w.raw_time_us = 64'd1006;
        send_word(w);
        w.raw_time_us = 64'd1007;
        send_word(w);
        w.raw_time_us = ALL_ONES;
        send_word(w);
        w.raw_time_us = 64'd0;
        send_word(w);
    endtask

    // sample mode: each check, in priority order
    task automatic test_sample_checks();
        t_time_word w;
        set_registers(64'd100_000_000, 64'd250, 8'hA5);
        // floor equal to the sample time is still fresh
        w = good_sample(64'd200, 32'd123456, 8'd1);
        w.epoch_floor_us = 64'd200_123_456;
        send_word(w);
        w = good_sample(64'd200, 32'd0, 8'd2);
        w.wall_clk_ok = 1'b0;
        send_word(w);
        w = good_sample(64'd200, 32'd0, 8'd2);
        w.time_src_ok = 1'b0;
        send_word(w);
        w = good_sample(64'd200, 32'd0, 8'd2);
        w.time_scale = 8'hA4;
        send_word(w);
        send_word(good_sample(64'd200, 32'd0, 8'd0));
        send_word(good_sample(64'd200, 32'd0, 8'd5));
        // negative seconds
        send_word(good_sample(64'h8000_0000_0000_0000, 32'd0, 8'd3));
        send_word(good_sample(64'd200, 32'd1000000, 8'd3));
        send_word(good_sample(64'd200, 32'd999999, 8'd4));
        // just past the 64-bit microsecond range
        send_word(good_sample(MAX_WHOLE_SECONDS, 32'd551616, 8'd1));
        send_word(good_sample(64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 8'd1));
        // stale floor
        w = good_sample(64'd300, 32'd5, 8'd2);
        w.epoch_floor_us = 64'd300_000_006;
        send_word(w);
        // sample before the epoch
        send_word(good_sample(64'd99, 32'd999999, 8'd2));
    endtask

    // register extremes and the spare index
    task automatic test_config_extremes();
        t_time_word w;
        set_registers(ALL_ONES, ALL_ONES, 8'hFF);
        send_word(good_sample(MAX_WHOLE_SECONDS, 32'd551615, 8'd4));
        w = noise_word();
        w.action = 1'b0;
        w.raw_time_us = ALL_ONES;
        send_word(w);
        w.raw_time_us = ALL_ONES - 1;
        send_word(w);
        set_registers(64'd0, 64'd1, 8'h00);
        write_reg(CFG_SPARE, ALL_ONES);
        w.raw_time_us = ALL_ONES;
        send_word(w);
        send_word(good_sample(MAX_WHOLE_SECONDS, 32'd551615, 8'd1));
    endtask

    task automatic run_random_phase(input logic [TIME_W-1:0] epoch,
                                    input logic [TIME_W-1:0] interval,
                                    input logic [SCALE_W-1:0] scale,
                                    input int unsigned count,
                                    input bit idle_on);
        set_registers(epoch, interval, scale);
        src_idle_on  = idle_on;
        sink_idle_on = idle_on;
        for (int unsigned i = 0; i < count; i++) begin
            // hold input halfway until the pipeline is empty
            if (i == count / 2) wait_for_results();
            if ($urandom_range(0, 99) < 30) send_word(make_raw_word());
            else send_word(make_sample_word(35));
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(64'd0, 64'd1, 8'h00, 80, 1'b1);
        run_random_phase(64'd1_700_000_000_000_000 + rand64() % 64'd1_000_000_000_000,
                         64'($urandom_range(1000, 60_000_000)), 8'h01, 90, 1'b1);
        run_random_phase(rand64(), rand64(), 8'($urandom_range(0, 255)), 80, 1'b1);
        // back to back, no stalls on either side
        run_random_phase({32'd0, $urandom}, 64'($urandom_range(1, 255)), 8'hFF, 80, 1'b0);
        run_random_phase(ALL_ONES, 64'd0, 8'h5A, 40, 1'b1);
        run_random_phase(ALL_ONES, ALL_ONES, 8'h80, 80, 1'b1);
    endtask

    // result side ready with random stalls
    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold  <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            sink_hold  <= stall_length() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin : check_result_words
        t_slot_result         want;
        logic [2:0]           got_status;
        logic [TIME_W-1:0]    got_slot;
        logic [FRAME_W-1:0]   got_frame;
        logic                 got_clamped;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_status  = o_m_tdata[2:0];
            got_slot    = o_m_tdata[66:3];
            got_frame   = o_m_tdata[98:67];
            got_clamped = o_m_tdata[99];
            if (slot_want_q.size() == 0) begin
                $error("result word with no prediction waiting");
                errors++;
            end else begin
                want = slot_want_q.pop_front();
                checked_words++;
                if (want.status <= ST_STALE) status_hits[want.status]++;
                if (want.clamped) clamp_hits++;
                if (got_status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    errors++;
                end
                if (got_slot != want.slot_number) begin
                    $error("slot_number: expected %0d, got %0d", want.slot_number, got_slot);
                    errors++;
                end
                if (got_frame != want.frame_number) begin
                    $error("frame_number: expected %0d, got %0d",
                           want.frame_number, got_frame);
                    errors++;
                end
                if (got_clamped != want.clamped) begin
                    $error("clamped: expected %0d, got %0d", want.clamped, got_clamped);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #3_000_000;
        $display("timeout with %0d result words outstanding", slot_want_q.size());
        $display("** gnss_time_to_slot_number: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = 1'b0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        cfg_epoch    = '0;
        cfg_interval = '0;
        cfg_scale    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_raw_mode();
        test_sample_checks();
        test_config_extremes();
        test_random_traffic();

        wait_for_results();
        repeat (80) @(posedge i_clk);
        if (slot_want_q.size() != 0) begin
            $error("%0d predicted result words never arrived", slot_want_q.size());
            errors++;
        end

        $display("covered %0d raw and %0d sample words, %0d register writes, %0d clamped",
                 raw_words, sample_words, reg_writes, clamp_hits);
        $display("checked %0d results; %s %0d/%0d/%0d/%0d/%0d/%0d",
                 checked_words, "ok/interval/untrusted/range/overflow/stale",
                 status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4], status_hits[5]);
        if (errors == 0) begin
            $display("** gnss_time_to_slot_number: PASSED **");
        end else begin
            $display("** gnss_time_to_slot_number: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gtsn_pkg.sv
hdl/gnss_time_to_slot_number.sv
tb/sv/gnss_time_to_slot_number_test.sv
